/* src/string_escape_decoder_unit_macros.svh */
// Assertion macros for the string escape decoder unit
`ifndef STRING_ESCAPE_DECODER_UNIT_MACROS_SVH
`define STRING_ESCAPE_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define SED_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`define SED_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

`else

`define SED_ASSERT_NEVER(lbl, expr)

`define SED_ASSERT_IMPLY(lbl, ante, cons)

`endif

`endif

/* src/sed_pkg.sv */
// Shared types, character codes and constants of the string escape decoder
package sed_pkg;

    localparam int POS_W       = 4;
    localparam int DIGIT_DEPTH = 7;
    localparam int DIGIT_IDX_W = 3;
    localparam int ACC_W       = 28;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_HEX   = 2'd2;

    localparam logic [1:0] KIND_X  = 2'd0;
    localparam logic [1:0] KIND_U  = 2'd1;
    localparam logic [1:0] KIND_UU = 2'd2;

    localparam logic [7:0] CHAR_BSLASH = 8'h5c;
    localparam logic [7:0] CHAR_N      = 8'h6e;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_B      = 8'h62;
    localparam logic [7:0] CHAR_F      = 8'h66;
    localparam logic [7:0] CHAR_A      = 8'h61;
    localparam logic [7:0] CHAR_V      = 8'h76;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_U_LO   = 8'h75;
    localparam logic [7:0] CHAR_U_HI   = 8'h55;

    localparam logic [7:0] CTRL_LF  = 8'h0a;
    localparam logic [7:0] CTRL_CR  = 8'h0d;
    localparam logic [7:0] CTRL_TAB = 8'h09;
    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_FF  = 8'h0c;
    localparam logic [7:0] CTRL_BEL = 8'h07;
    localparam logic [7:0] CTRL_VT  = 8'h0b;

    localparam logic [31:0] CP_MAX1 = 32'h7f;
    localparam logic [31:0] CP_MAX2 = 32'h7ff;
    localparam logic [31:0] CP_MAX3 = 32'hffff;

    localparam logic [7:0] UTF_LEAD2 = 8'hc0;
    localparam logic [7:0] UTF_LEAD3 = 8'he0;
    localparam logic [7:0] UTF_LEAD4 = 8'hf0;
    localparam logic [7:0] UTF_CONT  = 8'h80;
    localparam logic [5:0] UTF_MASK  = 6'h3f;

    typedef struct packed {
        logic             load_job;
        logic             emit;
        logic             is_final;
        logic [POS_W-1:0] pos;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [POS_W-1:0] job_count;
    } dp_stat_t;

endpackage

/* src/sed_datapath.sv */
// Datapath: escape decoding state, digit store, job registers and output byte register
module sed_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           in_byte,
    input  logic                 raw_string,
    input  logic                 last_byte,
    input  sed_pkg::ctrl_cmd_t   cmd,
    output sed_pkg::dp_stat_t    stat,
    output logic [7:0]           out_byte,
    output logic                 end_of_string
);
    import sed_pkg::*;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[8'h30:8'h39]})
            r = {1'b1, c[3:0]};
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        return r;
    endfunction

    function automatic logic [3:0] kind_digits(input logic [1:0] k);
        logic [3:0] r;
        case (k)
            KIND_X:  r = 4'd2;
            KIND_U:  r = 4'd4;
            default: r = 4'd8;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kind_letter(input logic [1:0] k);
        logic [7:0] r;
        case (k)
            KIND_X:  r = CHAR_X;
            KIND_U:  r = CHAR_U_LO;
            default: r = CHAR_U_HI;
        endcase
        return r;
    endfunction

    logic [1:0]       mode_reg, mode_next;
    logic [1:0]       kind_reg, kind_next;
    logic [2:0]       dig_reg, dig_next;
    logic [ACC_W-1:0] acc_reg, acc_next;

    logic [7:0] digit_reg [DIGIT_DEPTH];
    logic       dwr_en;

    logic             job_flush_reg, job_flush_next;
    logic [2:0]       job_nd_reg, job_nd_next;
    logic [7:0]       job_letter_reg, job_letter_next;
    logic [3:0][7:0]  job_tail_reg, job_tail_next;
    logic             job_last_reg;
    logic [2:0]       tail_cnt;

    logic [7:0]  out_byte_reg, out_byte_next;
    logic        end_reg;

    logic [4:0]  hv;
    logic [31:0] cp;
    logic [POS_W-1:0] pre_len, tail_idx, dig_idx;

    assign hv = hex_val(in_byte);
    assign cp = {acc_reg, hv[3:0]};

    always_comb
    begin
        mode_next       = mode_reg;
        kind_next       = kind_reg;
        dig_next        = dig_reg;
        acc_next        = acc_reg;
        dwr_en          = 1'b0;
        job_flush_next  = 1'b0;
        job_nd_next     = 3'd0;
        job_letter_next = kind_letter(kind_reg);
        job_tail_next   = '0;
        tail_cnt        = 3'd0;
        if (raw_string)
        begin
            mode_next        = MODE_PLAIN;
            dig_next         = 3'd0;
            acc_next         = '0;
            job_tail_next[0] = in_byte;
            tail_cnt         = 3'd1;
        end
        else
        begin
            case (mode_reg)
                MODE_ESC:
                begin
                    mode_next = MODE_PLAIN;
                    tail_cnt  = 3'd1;
                    case (in_byte)
                        CHAR_N:  job_tail_next[0] = CTRL_LF;
                        CHAR_R:  job_tail_next[0] = CTRL_CR;
                        CHAR_T:  job_tail_next[0] = CTRL_TAB;
                        CHAR_B:  job_tail_next[0] = CTRL_BS;
                        CHAR_F:  job_tail_next[0] = CTRL_FF;
                        CHAR_A:  job_tail_next[0] = CTRL_BEL;
                        CHAR_V:  job_tail_next[0] = CTRL_VT;
                        CHAR_X, CHAR_U_LO, CHAR_U_HI:
                        begin
                            tail_cnt = 3'd0;
                            if (in_byte == CHAR_X)
                                kind_next = KIND_X;
                            else if (in_byte == CHAR_U_LO)
                                kind_next = KIND_U;
                            else
                                kind_next = KIND_UU;
                            dig_next = 3'd0;
                            acc_next = '0;
                            job_letter_next = in_byte;
                            if (last_byte)
                                job_flush_next = 1'b1;
                            else
                                mode_next = MODE_HEX;
                        end
                        default: job_tail_next[0] = in_byte;
                    endcase
                end
                MODE_HEX:
                begin
                    if (!hv[4])
                    begin
                        job_flush_next = 1'b1;
                        job_nd_next    = dig_reg;
                        dig_next       = 3'd0;
                        acc_next       = '0;
                        mode_next      = MODE_PLAIN;
                        if (in_byte == CHAR_BSLASH && !last_byte)
                            mode_next = MODE_ESC;
                        else
                        begin
                            job_tail_next[0] = in_byte;
                            tail_cnt         = 3'd1;
                        end
                    end
                    else if ({1'b0, dig_reg} + 4'd1 >= kind_digits(kind_reg))
                    begin
                        mode_next = MODE_PLAIN;
                        dig_next  = 3'd0;
                        acc_next  = '0;
                        if (cp <= CP_MAX1)
                        begin
                            job_tail_next[0] = cp[7:0];
                            tail_cnt         = 3'd1;
                        end
                        else if (cp <= CP_MAX2)
                        begin
                            job_tail_next[0] = UTF_LEAD2 | {3'b000, cp[10:6]};
                            job_tail_next[1] = UTF_CONT | {2'b00, cp[5:0] & UTF_MASK};
                            tail_cnt         = 3'd2;
                        end
                        else if (cp <= CP_MAX3)
                        begin
                            job_tail_next[0] = UTF_LEAD3 | {4'h0, cp[15:12]};
                            job_tail_next[1] = UTF_CONT | {2'b00, cp[11:6] & UTF_MASK};
                            job_tail_next[2] = UTF_CONT | {2'b00, cp[5:0] & UTF_MASK};
                            tail_cnt         = 3'd3;
                        end
                        else
                        begin
                            job_tail_next[0] = UTF_LEAD4 | cp[25:18];
                            job_tail_next[1] = UTF_CONT | {2'b00, cp[17:12] & UTF_MASK};
                            job_tail_next[2] = UTF_CONT | {2'b00, cp[11:6] & UTF_MASK};
                            job_tail_next[3] = UTF_CONT | {2'b00, cp[5:0] & UTF_MASK};
                            tail_cnt         = 3'd4;
                        end
                    end
                    else
                    begin
                        dwr_en   = 1'b1;
                        acc_next = cp[ACC_W-1:0];
                        dig_next = dig_reg + 3'd1;
                        if (last_byte)
                        begin
                            job_flush_next = 1'b1;
                            job_nd_next    = dig_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    if (in_byte == CHAR_BSLASH && !last_byte)
                        mode_next = MODE_ESC;
                    else
                    begin
                        mode_next        = MODE_PLAIN;
                        job_tail_next[0] = in_byte;
                        tail_cnt         = 3'd1;
                    end
                end
            endcase
        end
        if (last_byte)
        begin
            mode_next = MODE_PLAIN;
            dig_next  = 3'd0;
            acc_next  = '0;
        end
    end

    assign stat.job_count = job_flush_next
        ? POS_W'(4'd2 + {1'b0, job_nd_next} + {1'b0, tail_cnt})
        : POS_W'({1'b0, tail_cnt});

    assign pre_len  = job_flush_reg ? POS_W'(4'd2 + {1'b0, job_nd_reg}) : '0;
    assign tail_idx = cmd.pos - pre_len;
    assign dig_idx  = cmd.pos - POS_W'(2);

    always_comb
    begin
        if (job_flush_reg && cmd.pos == '0)
            out_byte_next = CHAR_BSLASH;
        else if (job_flush_reg && cmd.pos == POS_W'(1))
            out_byte_next = job_letter_reg;
        else if (job_flush_reg && cmd.pos < pre_len)
            out_byte_next = digit_reg[dig_idx[DIGIT_IDX_W-1:0]];
        else
            out_byte_next = job_tail_reg[tail_idx[1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            kind_reg <= KIND_X;
            dig_reg  <= 3'd0;
            acc_reg  <= '0;
        end
        else if (cmd.load_job)
        begin
            mode_reg <= mode_next;
            kind_reg <= kind_next;
            dig_reg  <= dig_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_job)
        begin
            job_flush_reg  <= job_flush_next;
            job_nd_reg     <= job_nd_next;
            job_letter_reg <= job_letter_next;
            job_tail_reg   <= job_tail_next;
            job_last_reg   <= last_byte;
            if (dwr_en)
                digit_reg[dig_reg] <= in_byte;
        end
        if (cmd.emit)
        begin
            out_byte_reg <= out_byte_next;
            end_reg      <= job_last_reg && cmd.is_final;
        end
    end

    assign out_byte      = out_byte_reg;
    assign end_of_string = end_reg;

endmodule

/* src/sed_controller.sv */
// Controller: request handshakes and sequencing of the decoded bytes of each request
module sed_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  sed_pkg::dp_stat_t   stat,
    output sed_pkg::ctrl_cmd_t  cmd
);
    import sed_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic             state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free, on_final, emit, accept;

    assign slot_free = !out_valid_reg || out_ready;
    assign on_final  = (pos_reg == count_reg - POS_W'(1));
    assign emit      = (state_reg == ST_EMIT) && slot_free;
    assign in_ready  = slot_free && ((state_reg == ST_IDLE) || on_final);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    pos_next       = pos_reg + POS_W'(1);
                    if (on_final)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (accept && stat.job_count != '0)
        begin
            state_next = ST_EMIT;
            pos_next   = '0;
            count_next = stat.job_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cmd.load_job = accept;
    assign cmd.emit     = emit;
    assign cmd.is_final = on_final;
    assign cmd.pos      = pos_reg;
    assign out_valid    = out_valid_reg;

endmodule

/* src/string_escape_decoder_unit.sv */
// Top level of the string escape decoder: controller, datapath and checks
//
// Input channel (in_valid/in_ready) takes one byte of a string body per
// request with raw_string and last_byte. Output channel (out_valid/out_ready)
// gives decoded bytes; end_of_string marks the final byte of a string.
// A request producing N bytes (N from 0 to 10) holds the input until its
// final byte: the controller's byte sequencer emits one byte per cycle into
// the single output register while it is free, from the job registers.
// Plain and raw bytes stream at one request per cycle while the receiver
// takes each byte; an escape-opening request produces nothing and leaves
// the input ready. Completed hex escapes give 1 to 4 bytes, failed up to 10.
// Reset returns to plain text mode with the output register empty.
// When the receiver stalls, the output byte holds and the sequencer and the
// input channel wait until the output register is taken.
module string_escape_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       raw_string,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       end_of_string
);
    import sed_pkg::*;

`include "string_escape_decoder_unit_macros.svh"

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    sed_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dp_stat),
        .cmd       (ctrl_cmd)
    );

    sed_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_byte       (in_byte),
        .raw_string    (raw_string),
        .last_byte     (last_byte),
        .cmd           (ctrl_cmd),
        .stat          (dp_stat),
        .out_byte      (out_byte),
        .end_of_string (end_of_string)
    );

    `SED_ASSERT_NEVER(a_ready_needs_slot, in_ready && out_valid && !out_ready)
    `SED_ASSERT_IMPLY(a_raw_one_byte, in_valid && in_ready && raw_string, dp_stat.job_count == POS_W'(1))
    `SED_ASSERT_IMPLY(a_last_gives_output, in_valid && in_ready && last_byte, dp_stat.job_count != '0)
    `SED_ASSERT_NEVER(a_emit_and_load_overlap, ctrl_cmd.emit && ctrl_cmd.load_job && !ctrl_cmd.is_final)

endmodule
